/* rtl/distinct_permutation_enumerator_macros.svh */
// Assertion macros for the distinct permutation enumerator.
// Included by the controller and the datapath; no other dependencies.
`ifndef DISTINCT_PERMUTATION_ENUMERATOR_MACROS_SVH
`define DISTINCT_PERMUTATION_ENUMERATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Check prop at every clock edge outside reset.
`define DPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define DPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/dpe_pkg.sv */
// Shared types and constants of the distinct permutation enumerator.
// Used by the channel interfaces, the controller and the datapath.
package dpe_pkg;

    localparam int LETTER_W = 8;

    // Input action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_NEXT = 1'b1;

    // Datapath commands issued by the controller, one per cycle
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FIRST,
        CMD_NOMORE,
        CMD_PV_INIT,
        CMD_INS_RD,
        CMD_INS_CMP,
        CMD_PV_FIRST,
        CMD_PV_SCAN,
        CMD_J_INIT,
        CMD_J_SCAN,
        CMD_SWAP,
        CMD_RV_CHK,
        CMD_RV_RDHI,
        CMD_RV_WLO,
        CMD_RV_WHI,
        CMD_EMIT_RD,
        CMD_EMIT_LD,
        CMD_EXH
    } t_cmd;

    // Datapath status seen by the controller
    typedef struct packed {
        logic out_free;
        logic req_exh;
        logic first_given;
        logic cnt_lt2;
        logic load_fits;
        logic idx_zero;
        logic rd_gt_ins;
        logic rd_lt_prev;
        logic rd_gt_pval;
        logic lo_lt_hi;
        logic idx_last;
    } t_sts;

endpackage

/* rtl/dpe_in_if.sv */
// Input channel of the distinct permutation enumerator: valid/ready plus one item.
// Depends on dpe_pkg for the letter width.
interface dpe_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [dpe_pkg::LETTER_W-1:0]  letter;
    logic                          last_letter;

    modport source (output valid, action, letter, last_letter, input ready);
    modport sink   (input valid, action, letter, last_letter, output ready);
endinterface

/* rtl/dpe_out_if.sv */
// Output channel of the distinct permutation enumerator: valid/ready plus one result.
// Depends on dpe_pkg for the letter width.
interface dpe_out_if;
    logic                          valid;
    logic                          ready;
    logic [dpe_pkg::LETTER_W-1:0]  out_letter;
    logic                          end_of_run;
    logic                          exhausted;
    logic                          overflow;

    modport source (output valid, out_letter, end_of_run, exhausted, overflow, input ready);
    modport sink   (input valid, out_letter, end_of_run, exhausted, overflow, output ready);
endinterface

/* rtl/dpe_ctrl.sv */
// Sequencer of the distinct permutation enumerator: one-hot state machine that
// issues datapath commands. Depends on dpe_pkg and the assertion macro header.
`include "distinct_permutation_enumerator_macros.svh"

module dpe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_action,
    output logic          o_in_ready,
    output dpe_pkg::t_cmd o_cmd,
    input  dpe_pkg::t_sts i_sts
);

    typedef enum logic [14:0] {
        ST_IDLE     = 15'h0001,
        ST_INS_RD   = 15'h0002,
        ST_INS_CMP  = 15'h0004,
        ST_PV_FIRST = 15'h0008,
        ST_PV_SCAN  = 15'h0010,
        ST_J_INIT   = 15'h0020,
        ST_J_SCAN   = 15'h0040,
        ST_SWAP     = 15'h0080,
        ST_RV_CHK   = 15'h0100,
        ST_RV_RDHI  = 15'h0200,
        ST_RV_WLO   = 15'h0400,
        ST_RV_WHI   = 15'h0800,
        ST_EMIT_RD  = 15'h1000,
        ST_EMIT_LD  = 15'h2000,
        ST_EXH      = 15'h4000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = dpe_pkg::CMD_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == dpe_pkg::ACT_LOAD) begin
                        o_cmd   = dpe_pkg::CMD_LOAD;
                        n_state = i_sts.load_fits ? ST_INS_RD : ST_IDLE;
                    end else if (i_sts.req_exh) begin
                        n_state = ST_EXH;
                    end else if (!i_sts.first_given) begin
                        o_cmd   = dpe_pkg::CMD_FIRST;
                        n_state = ST_EMIT_RD;
                    end else if (i_sts.cnt_lt2) begin
                        o_cmd   = dpe_pkg::CMD_NOMORE;
                        n_state = ST_EXH;
                    end else begin
                        o_cmd   = dpe_pkg::CMD_PV_INIT;
                        n_state = ST_PV_FIRST;
                    end
                end
            end
            ST_INS_RD: begin
                o_cmd   = dpe_pkg::CMD_INS_RD;
                n_state = i_sts.idx_zero ? ST_IDLE : ST_INS_CMP;
            end
            ST_INS_CMP: begin
                o_cmd   = dpe_pkg::CMD_INS_CMP;
                n_state = i_sts.rd_gt_ins ? ST_INS_RD : ST_IDLE;
            end
            ST_PV_FIRST: begin
                o_cmd   = dpe_pkg::CMD_PV_FIRST;
                n_state = ST_PV_SCAN;
            end
            ST_PV_SCAN: begin
                o_cmd = dpe_pkg::CMD_PV_SCAN;
                if (i_sts.rd_lt_prev) begin
                    n_state = ST_J_INIT;
                end else if (i_sts.idx_zero) begin
                    n_state = ST_EXH;
                end
            end
            ST_J_INIT: begin
                o_cmd   = dpe_pkg::CMD_J_INIT;
                n_state = ST_J_SCAN;
            end
            ST_J_SCAN: begin
                o_cmd = dpe_pkg::CMD_J_SCAN;
                if (i_sts.rd_gt_pval) begin
                    n_state = ST_SWAP;
                end
            end
            ST_SWAP: begin
                o_cmd   = dpe_pkg::CMD_SWAP;
                n_state = ST_RV_CHK;
            end
            ST_RV_CHK: begin
                o_cmd   = dpe_pkg::CMD_RV_CHK;
                n_state = i_sts.lo_lt_hi ? ST_RV_RDHI : ST_EMIT_RD;
            end
            ST_RV_RDHI: begin
                o_cmd   = dpe_pkg::CMD_RV_RDHI;
                n_state = ST_RV_WLO;
            end
            ST_RV_WLO: begin
                o_cmd   = dpe_pkg::CMD_RV_WLO;
                n_state = ST_RV_WHI;
            end
            ST_RV_WHI: begin
                o_cmd   = dpe_pkg::CMD_RV_WHI;
                n_state = ST_RV_CHK;
            end
            ST_EMIT_RD: begin
                o_cmd = dpe_pkg::CMD_EMIT_RD;
                if (i_sts.out_free) begin
                    n_state = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                o_cmd   = dpe_pkg::CMD_EMIT_LD;
                n_state = i_sts.idx_last ? ST_IDLE : ST_EMIT_RD;
            end
            ST_EXH: begin
                o_cmd = dpe_pkg::CMD_EXH;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `DPE_ASSERT_NEXT(a_req_exh_path, i_clk, i_rst_n, (r_state == ST_IDLE) && i_in_valid && (i_action == dpe_pkg::ACT_NEXT) && i_sts.req_exh, r_state == ST_EXH, "request without a word did not go to exhausted reply")
    `DPE_ASSERT(a_ins_cmp_order, i_clk, i_rst_n, (r_state == ST_INS_CMP) |-> ($past(r_state) == ST_INS_RD), "insert compare without a preceding read")
    `DPE_ASSERT(a_emit_order, i_clk, i_rst_n, (r_state == ST_EMIT_LD) |-> ($past(r_state) == ST_EMIT_RD), "emit load without a preceding read")

endmodule

/* rtl/dpe_datapath.sv */
// Datapath of the distinct permutation enumerator: letter memory, scan indexes,
// word flags and the output beat register. Depends on dpe_pkg and the macro header.
`include "distinct_permutation_enumerator_macros.svh"

module dpe_datapath #(
    parameter int MAX_LETTERS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dpe_pkg::t_cmd                 i_cmd,
    output dpe_pkg::t_sts                 o_sts,
    input  logic [dpe_pkg::LETTER_W-1:0]  i_letter,
    input  logic                          i_last_letter,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [dpe_pkg::LETTER_W-1:0]  o_out_letter,
    output logic                          o_end_of_run,
    output logic                          o_exhausted,
    output logic                          o_overflow
);

    localparam int LW = dpe_pkg::LETTER_W;
    localparam int AW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam int CW = $clog2(MAX_LETTERS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LETTERS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    logic [LW-1:0] r_mem [0:MAX_LETTERS-1];
    logic [LW-1:0] r_rd;

    logic [CW-1:0] r_count, n_count;
    logic          r_complete, n_complete;
    logic          r_first, n_first;
    logic          r_nomore, n_nomore;
    logic          r_trunc, n_trunc;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [LW-1:0] r_prev, n_prev;
    logic [LW-1:0] r_pval, n_pval;
    logic [LW-1:0] r_ins, n_ins;
    logic [LW-1:0] r_tmp, n_tmp;

    logic          r_ov;
    logic [LW-1:0] r_o_letter;
    logic          r_o_end;
    logic          r_o_exh;
    logic          r_o_ovf;

    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [LW-1:0] w_wdata;
    logic          w_oload;
    logic [LW-1:0] w_o_letter;
    logic          w_o_end;
    logic          w_o_exh;

    logic [CW-1:0] w_eff;
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_idx_m1;

    assign w_eff    = r_complete ? '0 : r_count;
    assign w_cnt_m1 = r_count - ONE;
    assign w_idx_m1 = r_idx - ONE;

    assign o_sts.out_free    = !r_ov || i_out_ready;
    assign o_sts.req_exh     = !r_complete || (r_count == '0) || r_nomore;
    assign o_sts.first_given = r_first;
    assign o_sts.cnt_lt2     = (r_count <= ONE);
    assign o_sts.load_fits   = r_complete || (r_count < MAX_CNT);
    assign o_sts.idx_zero    = (r_idx == '0);
    assign o_sts.rd_gt_ins   = (r_rd > r_ins);
    assign o_sts.rd_lt_prev  = (r_rd < r_prev);
    assign o_sts.rd_gt_pval  = (r_rd > r_pval);
    assign o_sts.lo_lt_hi    = (r_lo < r_hi);
    assign o_sts.idx_last    = (r_idx == w_cnt_m1);

    always_comb begin
        n_count    = r_count;
        n_complete = r_complete;
        n_first    = r_first;
        n_nomore   = r_nomore;
        n_trunc    = r_trunc;
        n_idx      = r_idx;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_prev     = r_prev;
        n_pval     = r_pval;
        n_ins      = r_ins;
        n_tmp      = r_tmp;
        w_re       = 1'b0;
        w_raddr    = r_idx[AW-1:0];
        w_we       = 1'b0;
        w_waddr    = r_idx[AW-1:0];
        w_wdata    = r_ins;
        w_oload    = 1'b0;
        w_o_letter = r_rd;
        w_o_end    = 1'b0;
        w_o_exh    = 1'b0;
        case (i_cmd)
            dpe_pkg::CMD_LOAD: begin
                // A load after a finished word restarts the word.
                if (r_complete) begin
                    n_first  = 1'b0;
                    n_nomore = 1'b0;
                    n_trunc  = 1'b0;
                end
                n_complete = i_last_letter;
                n_ins      = i_letter;
                n_idx      = w_eff;
                if (o_sts.load_fits) begin
                    n_count = w_eff + ONE;
                end else begin
                    n_trunc = 1'b1;
                end
            end
            dpe_pkg::CMD_FIRST: begin
                n_first = 1'b1;
                n_idx   = '0;
            end
            dpe_pkg::CMD_NOMORE: begin
                n_nomore = 1'b1;
            end
            dpe_pkg::CMD_PV_INIT: begin
                n_idx   = w_cnt_m1;
                w_re    = 1'b1;
                w_raddr = w_cnt_m1[AW-1:0];
            end
            dpe_pkg::CMD_INS_RD: begin
                if (o_sts.idx_zero) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = r_ins;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_m1[AW-1:0];
                end
            end
            dpe_pkg::CMD_INS_CMP: begin
                // Shift a larger letter up one place, or drop the new one in.
                w_we = 1'b1;
                if (o_sts.rd_gt_ins) begin
                    w_wdata = r_rd;
                    n_idx   = w_idx_m1;
                end else begin
                    w_wdata = r_ins;
                end
            end
            dpe_pkg::CMD_PV_FIRST: begin
                n_prev  = r_rd;
                w_re    = 1'b1;
                w_raddr = w_idx_m1[AW-1:0];
                n_idx   = w_idx_m1;
            end
            dpe_pkg::CMD_PV_SCAN: begin
                if (o_sts.rd_lt_prev) begin
                    n_lo   = r_idx;
                    n_pval = r_rd;
                end else if (o_sts.idx_zero) begin
                    n_nomore = 1'b1;
                end else begin
                    n_prev  = r_rd;
                    w_re    = 1'b1;
                    w_raddr = w_idx_m1[AW-1:0];
                    n_idx   = w_idx_m1;
                end
            end
            dpe_pkg::CMD_J_INIT: begin
                n_idx   = w_cnt_m1;
                w_re    = 1'b1;
                w_raddr = w_cnt_m1[AW-1:0];
            end
            dpe_pkg::CMD_J_SCAN: begin
                if (o_sts.rd_gt_pval) begin
                    // First half of the swap: successor goes to the pivot slot.
                    w_we    = 1'b1;
                    w_waddr = r_lo[AW-1:0];
                    w_wdata = r_rd;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_m1[AW-1:0];
                    n_idx   = w_idx_m1;
                end
            end
            dpe_pkg::CMD_SWAP: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = r_pval;
                n_lo    = r_lo + ONE;
                n_hi    = w_cnt_m1;
            end
            dpe_pkg::CMD_RV_CHK: begin
                if (o_sts.lo_lt_hi) begin
                    w_re    = 1'b1;
                    w_raddr = r_lo[AW-1:0];
                end else begin
                    n_idx = '0;
                end
            end
            dpe_pkg::CMD_RV_RDHI: begin
                n_tmp   = r_rd;
                w_re    = 1'b1;
                w_raddr = r_hi[AW-1:0];
            end
            dpe_pkg::CMD_RV_WLO: begin
                w_we    = 1'b1;
                w_waddr = r_lo[AW-1:0];
                w_wdata = r_rd;
            end
            dpe_pkg::CMD_RV_WHI: begin
                w_we    = 1'b1;
                w_waddr = r_hi[AW-1:0];
                w_wdata = r_tmp;
                n_lo    = r_lo + ONE;
                n_hi    = r_hi - ONE;
            end
            dpe_pkg::CMD_EMIT_RD: begin
                if (o_sts.out_free) begin
                    w_re    = 1'b1;
                    w_raddr = r_idx[AW-1:0];
                end
            end
            dpe_pkg::CMD_EMIT_LD: begin
                w_oload    = 1'b1;
                w_o_letter = r_rd;
                w_o_end    = o_sts.idx_last;
                n_idx      = r_idx + ONE;
            end
            dpe_pkg::CMD_EXH: begin
                if (o_sts.out_free) begin
                    w_oload    = 1'b1;
                    w_o_letter = '0;
                    w_o_end    = 1'b1;
                    w_o_exh    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Letter store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_complete <= 1'b0;
            r_first    <= 1'b0;
            r_nomore   <= 1'b0;
            r_trunc    <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_complete <= n_complete;
            r_first    <= n_first;
            r_nomore   <= n_nomore;
            r_trunc    <= n_trunc;
            if (w_oload) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_prev <= n_prev;
        r_pval <= n_pval;
        r_ins  <= n_ins;
        r_tmp  <= n_tmp;
        if (w_oload) begin
            r_o_letter <= w_o_letter;
            r_o_end    <= w_o_end;
            r_o_exh    <= w_o_exh;
            r_o_ovf    <= r_trunc;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_letter = r_o_letter;
    assign o_end_of_run = r_o_end;
    assign o_exhausted  = r_o_exh;
    assign o_overflow   = r_o_ovf;

    `DPE_ASSERT(a_trunc_full, i_clk, i_rst_n, r_trunc |-> (r_count == MAX_CNT), "truncated word with a store that is not full")
    `DPE_ASSERT(a_nomore_state, i_clk, i_rst_n, r_nomore |-> (r_first && r_complete), "exhausted flag on a word that was never emitted")
    `DPE_ASSERT(a_no_overwrite, i_clk, i_rst_n, w_oload |-> (!r_ov || i_out_ready), "output beat loaded over a beat not yet taken")

endmodule

/* rtl/distinct_permutation_enumerator.sv */
// Distinct permutation enumerator: loads a word letter by letter, keeps it sorted
// and emits its distinct permutations in lexicographic order, one per request.
// Depends on dpe_pkg, dpe_in_if, dpe_out_if, dpe_ctrl and dpe_datapath.
//
// Usage: i_in carries one item per beat. action = load puts one letter into the
// store, kept in ascending order by insertion; last_letter closes the word. A
// load after a closed word starts a new word. Letters past MAX_LETTERS are
// dropped and the overflow bit is set on every later result of that word.
// action = next answers with n result beats on o_out (end_of_run on the last),
// or with one exhausted beat when no word is closed or all permutations are out.
// Sequence, for a word of n letters, all through the letter memory:
//   load: each larger letter is shifted up one place, then the new one is written;
//   a dropped letter is not stored.
//   first request: emission of the sorted word; later requests: pivot scan,
//   successor scan, swap, reversal of the suffix pair by pair, then emission.
// Reset: no word loaded; a request answers exhausted. The store is not cleared.
// A stalled receiver holds the output register; the block waits for it to drain.
module distinct_permutation_enumerator #(
    parameter int MAX_LETTERS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpe_in_if.sink     i_in,
    dpe_out_if.source  o_out
);

    dpe_pkg::t_cmd w_cmd;
    dpe_pkg::t_sts w_sts;
    logic          w_in_ready;

    dpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    dpe_datapath #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_letter      (i_in.letter),
        .i_last_letter (i_in.last_letter),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_letter  (o_out.out_letter),
        .o_end_of_run  (o_out.end_of_run),
        .o_exhausted   (o_out.exhausted),
        .o_overflow    (o_out.overflow)
    );

    assign i_in.ready = w_in_ready;

endmodule
